/* rtl/cts_pkg.sv */
// Package for the tick scheduler: sizes, command and status types, codes.
// Used by cts_ctrl, cts_datapath and the top level; no dependencies.
package cts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    // configuration register indexes
    localparam logic CFG_POLICY  = 1'b0;
    localparam logic CFG_QUANTUM = 1'b1;

    // scheduling policies
    localparam logic [1:0] POL_RR   = 2'd0;
    localparam logic [1:0] POL_RANK = 2'd1;
    localparam logic [1:0] POL_SJF  = 2'd2;
    localparam logic [1:0] POL_RR_B = 2'd3;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // item kinds
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_TSTART, OP_WSTEP, OP_DECIDE,
        OP_SINIT, OP_SSTEP, OP_SPICK, OP_SHIFT, OP_RUN
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic wscan_done;
        logic sel_need;
        logic sscan_done;
        logic shift_done;
    } t_stat;

endpackage

/* rtl/cts_in_if.sv */
// Input channel of the tick scheduler: valid/ready plus one load or tick word.
// Depends on nothing.
interface cts_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  task_id;
    logic [15:0] burst_time;
    logic [7:0]  rank;
    logic [15:0] io_frequency;
    logic [15:0] io_duration;

    modport source (output valid, mode, task_id, burst_time, rank, io_frequency,
                    io_duration, input ready);
    modport sink   (input valid, mode, task_id, burst_time, rank, io_frequency,
                    io_duration, output ready);
endinterface

/* rtl/cts_out_if.sv */
// Result channel of the tick scheduler: valid/ready plus one result word.
// Depends on nothing.
interface cts_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        running_valid;
    logic [7:0]  running_id;
    logic        finished_valid;
    logic [7:0]  finished_id;
    logic [31:0] finish_time;
    logic        all_done;
    logic [31:0] time_now;

    modport source (output valid, accepted, running_valid, running_id, finished_valid,
                    finished_id, finish_time, all_done, time_now, input ready);
    modport sink   (input valid, accepted, running_valid, running_id, finished_valid,
                    finished_id, finish_time, all_done, time_now, output ready);
endinterface

/* rtl/cts_ctrl.sv */
// Sequencer of the tick scheduler: walks a tick through its phases.
// Depends on cts_pkg; drives cts_datapath through t_cmd, reads t_stat.
module cts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_mode,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  cts_pkg::t_stat i_stat,
    output cts_pkg::t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_WSCAN  = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_SEL    = 9'b000001000,
        S_SSCAN  = 9'b000010000,
        S_PICK   = 9'b000100000,
        S_SHIFT  = 9'b001000000,
        S_RESP   = 9'b010000000,
        S_SPARE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // next state and command
    always_comb begin
        n_state     = r_state;
        o_cmd.op    = cts_pkg::OP_NONE;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_mode == cts_pkg::MODE_LOAD) begin
                        o_cmd.op = cts_pkg::OP_LOAD;
                        n_state  = S_RESP;
                    end else begin
                        o_cmd.op = cts_pkg::OP_TSTART;
                        n_state  = S_WSCAN;
                    end
                end
            end
            S_WSCAN: begin
                o_cmd.op = cts_pkg::OP_WSTEP;
                if (i_stat.wscan_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.op = cts_pkg::OP_DECIDE;
                n_state  = S_SEL;
            end
            S_SEL: begin
                if (i_stat.sel_need) begin
                    o_cmd.op = cts_pkg::OP_SINIT;
                    n_state  = S_SSCAN;
                end else begin
                    o_cmd.op = cts_pkg::OP_RUN;
                    n_state  = S_RESP;
                end
            end
            S_SSCAN: begin
                o_cmd.op = cts_pkg::OP_SSTEP;
                if (i_stat.sscan_done) n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.op = cts_pkg::OP_SPICK;
                n_state  = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    o_cmd.op = cts_pkg::OP_RUN;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.op = cts_pkg::OP_SHIFT;
                end
            end
            S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

/* rtl/cts_datapath.sv */
// Task table, ready and waiting lists, counters and result word of the scheduler.
// Depends on cts_pkg; commanded by cts_ctrl.
module cts_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cts_pkg::t_cmd  i_cmd,
    output cts_pkg::t_stat o_stat,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    input  logic [7:0]     i_task_id,
    input  logic [15:0]    i_burst_time,
    input  logic [7:0]     i_rank,
    input  logic [15:0]    i_io_frequency,
    input  logic [15:0]    i_io_duration,
    output logic           o_accepted,
    output logic           o_running_valid,
    output logic [7:0]     o_running_id,
    output logic           o_finished_valid,
    output logic [7:0]     o_finished_id,
    output logic [31:0]    o_finish_time,
    output logic           o_all_done,
    output logic [31:0]    o_time_now
);

    localparam int SW = cts_pkg::SLOT_W;
    localparam int CW = cts_pkg::CNT_W;

    // task table
    logic [7:0]  r_tid    [cts_pkg::MAX_TASKS];
    logic [15:0] r_rem    [cts_pkg::MAX_TASKS];
    logic [7:0]  r_rank   [cts_pkg::MAX_TASKS];
    logic [15:0] r_ioint  [cts_pkg::MAX_TASKS];
    logic [15:0] r_ioleft [cts_pkg::MAX_TASKS];
    logic [15:0] r_since  [cts_pkg::MAX_TASKS];
    logic [cts_pkg::MAX_TASKS-1:0] r_used;
    logic [SW-1:0] r_ro [cts_pkg::MAX_TASKS];
    logic [SW-1:0] r_wo [cts_pkg::MAX_TASKS];

    logic [CW-1:0] r_rcnt, r_wcnt, r_i, r_wr;
    logic [SW-1:0] r_run_slot, r_best;
    logic          r_run_flag;
    logic [15:0]   r_qused, r_bestkey, r_quantum;
    logic [31:0]   r_clock;
    logic [1:0]    r_policy;

    logic [CW-1:0] idx_inc;
    logic [SW-1:0] ro_addr, ro_rd, wo_rd, sl_addr, free_slot;
    logic          free_found, pol_min, done_now, stop;
    logic [15:0]   key, left_dec;

    assign idx_inc = r_i + 1'b1;
    assign pol_min = (r_policy == cts_pkg::POL_RANK) || (r_policy == cts_pkg::POL_SJF);
    assign done_now = (r_rcnt == '0) && (r_wcnt == '0) && !r_run_flag;

    // one read address for each list; the ready list's address is chosen by the phase
    always_comb begin
        case (i_cmd.op)
            cts_pkg::OP_SINIT: ro_addr = '0;
            cts_pkg::OP_SPICK: ro_addr = r_best;
            cts_pkg::OP_SHIFT: ro_addr = idx_inc[SW-1:0];
            default:           ro_addr = r_i[SW-1:0];
        endcase
    end
    assign ro_rd = r_ro[ro_addr];
    assign wo_rd = r_wo[r_i[SW-1:0]];

    always_comb begin
        case (i_cmd.op)
            cts_pkg::OP_WSTEP: sl_addr = wo_rd;
            cts_pkg::OP_SINIT,
            cts_pkg::OP_SSTEP: sl_addr = ro_rd;
            default:           sl_addr = r_run_slot;
        endcase
    end

    assign key      = (r_policy == cts_pkg::POL_RANK) ? {8'd0, r_rank[sl_addr]} : r_rem[sl_addr];
    assign left_dec = (r_ioleft[sl_addr] == '0) ? '0 : r_ioleft[sl_addr] - 16'd1;

    // first empty slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int k = 0; k < cts_pkg::MAX_TASKS; k++) begin
            if (!free_found && !r_used[k]) begin
                free_found = 1'b1;
                free_slot  = SW'(k);
            end
        end
    end

    // running task leaves the CPU in the decide phase
    assign stop = (r_rem[r_run_slot] == '0)
               || ((r_ioint[r_run_slot] != '0) && (r_since[r_run_slot] >= r_ioint[r_run_slot]))
               || (!pol_min && (r_qused >= r_quantum));

    assign o_stat.wscan_done = (r_i >= r_wcnt);
    assign o_stat.sel_need   = !r_run_flag && (r_rcnt != '0);
    assign o_stat.sscan_done = !((r_i < r_rcnt) && pol_min);
    assign o_stat.shift_done = (r_i >= r_rcnt);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_rcnt     <= '0;
            r_wcnt     <= '0;
            r_run_slot <= '0;
            r_run_flag <= 1'b0;
            r_qused    <= '0;
            r_clock    <= '0;
            r_policy   <= cts_pkg::POL_RR;
            r_quantum  <= 16'd4;
            r_i        <= '0;
            r_wr       <= '0;
            r_best     <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == cts_pkg::CFG_POLICY) r_policy  <= i_cfg_data[1:0];
                else                                  r_quantum <= i_cfg_data;
            end
            case (i_cmd.op)
                cts_pkg::OP_LOAD: begin
                    if (free_found) begin
                        r_used[free_slot] <= 1'b1;
                        r_rcnt            <= r_rcnt + 1'b1;
                    end
                end
                cts_pkg::OP_TSTART: begin
                    r_i  <= '0;
                    r_wr <= '0;
                end
                cts_pkg::OP_WSTEP: begin
                    if (r_i < r_wcnt) begin
                        r_i <= idx_inc;
                        if (left_dec == '0) r_rcnt <= r_rcnt + 1'b1;
                        else                r_wr   <= r_wr + 1'b1;
                    end else begin
                        r_wcnt <= r_wr;
                    end
                end
                cts_pkg::OP_DECIDE: begin
                    if (r_run_flag && stop) begin
                        r_run_flag <= 1'b0;
                        r_qused    <= '0;
                        if (r_rem[r_run_slot] == '0) r_used[r_run_slot] <= 1'b0;
                        else if ((r_ioint[r_run_slot] != '0)
                                 && (r_since[r_run_slot] >= r_ioint[r_run_slot]))
                            r_wcnt <= r_wcnt + 1'b1;
                        else r_rcnt <= r_rcnt + 1'b1;
                    end
                end
                cts_pkg::OP_SINIT: begin
                    r_i    <= CW'(1);
                    r_best <= '0;
                end
                cts_pkg::OP_SSTEP: begin
                    if ((r_i < r_rcnt) && pol_min) begin
                        r_i <= idx_inc;
                        if (key < r_bestkey) r_best <= r_i[SW-1:0];
                    end
                end
                cts_pkg::OP_SPICK: begin
                    r_run_slot <= ro_rd;
                    r_run_flag <= 1'b1;
                    r_rcnt     <= r_rcnt - 1'b1;
                    r_i        <= {{(CW-SW){1'b0}}, r_best};
                end
                cts_pkg::OP_SHIFT: r_i <= idx_inc;
                cts_pkg::OP_RUN: begin
                    if (r_run_flag && (r_qused != cts_pkg::CNT_MAX)) r_qused <= r_qused + 16'd1;
                    if (!done_now) r_clock <= r_clock + 32'd1;
                end
                default: ;
            endcase
        end
    end

    // table, list and result payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            cts_pkg::OP_LOAD: begin
                if (free_found) begin
                    r_tid[free_slot]    <= i_task_id;
                    r_rem[free_slot]    <= i_burst_time;
                    r_rank[free_slot]   <= i_rank;
                    r_ioint[free_slot]  <= i_io_frequency;
                    r_ioleft[free_slot] <= i_io_duration;
                    r_since[free_slot]  <= '0;
                    r_ro[r_rcnt[SW-1:0]] <= free_slot;
                end
                o_accepted       <= free_found;
                o_running_valid  <= 1'b0;
                o_running_id     <= '0;
                o_finished_valid <= 1'b0;
                o_finished_id    <= '0;
                o_finish_time    <= '0;
                o_all_done       <= free_found ? 1'b0 : done_now;
                o_time_now       <= r_clock;
            end
            cts_pkg::OP_TSTART: begin
                o_finished_valid <= 1'b0;
                o_finished_id    <= '0;
                o_finish_time    <= '0;
                o_time_now       <= r_clock;
            end
            cts_pkg::OP_WSTEP: begin
                if (r_i < r_wcnt) begin
                    r_ioleft[sl_addr] <= left_dec;
                    if (left_dec == '0) r_ro[r_rcnt[SW-1:0]] <= sl_addr;
                    else                r_wo[r_wr[SW-1:0]]   <= sl_addr;
                end
            end
            cts_pkg::OP_DECIDE: begin
                if (r_run_flag) begin
                    if (r_rem[r_run_slot] == '0) begin
                        o_finished_valid <= 1'b1;
                        o_finished_id    <= r_tid[r_run_slot];
                        o_finish_time    <= r_clock;
                    end else if ((r_ioint[r_run_slot] != '0)
                                 && (r_since[r_run_slot] >= r_ioint[r_run_slot])) begin
                        r_since[r_run_slot]  <= '0;
                        r_wo[r_wcnt[SW-1:0]] <= r_run_slot;
                    end else if (!pol_min && (r_qused >= r_quantum)) begin
                        r_ro[r_rcnt[SW-1:0]] <= r_run_slot;
                    end
                end
            end
            cts_pkg::OP_SINIT: r_bestkey <= key;
            cts_pkg::OP_SSTEP: begin
                if ((r_i < r_rcnt) && pol_min && (key < r_bestkey)) r_bestkey <= key;
            end
            cts_pkg::OP_SHIFT: r_ro[r_i[SW-1:0]] <= ro_rd;
            cts_pkg::OP_RUN: begin
                o_accepted      <= 1'b0;
                o_running_valid <= r_run_flag;
                o_running_id    <= r_run_flag ? r_tid[r_run_slot] : 8'd0;
                o_all_done      <= done_now;
                if (r_run_flag) begin
                    if (r_rem[r_run_slot] != '0) r_rem[r_run_slot] <= r_rem[r_run_slot] - 16'd1;
                    if (r_since[r_run_slot] != cts_pkg::CNT_MAX)
                        r_since[r_run_slot] <= r_since[r_run_slot] + 16'd1;
                end
            end
            default: ;
        endcase
    end

endmodule

/* rtl/cpu_tick_scheduler_top.sv */
// Tick scheduler over a table of cts_pkg::MAX_TASKS task slots. One word is taken
// at a time: a load word's result is offered in the cycle after it is taken; a tick
// word first steps the waiting tasks through the I/O countdown, one per cycle, then,
// if no task runs, makes one pass over the ready queue for the rank or shortest-
// remaining search and one pass to close the gap in the queue; round robin skips the
// search pass. The result word then waits on the output until taken.
// Top level: joins cts_ctrl and cts_datapath; depends on cts_pkg and the interfaces.
module cpu_tick_scheduler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cts_in_if.sink      i_in,
    cts_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    cts_pkg::t_cmd  cmd;
    cts_pkg::t_stat stat;

    // phase sequencer
    cts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // tables and counters
    cts_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_task_id        (i_in.task_id),
        .i_burst_time     (i_in.burst_time),
        .i_rank           (i_in.rank),
        .i_io_frequency   (i_in.io_frequency),
        .i_io_duration    (i_in.io_duration),
        .o_accepted       (o_out.accepted),
        .o_running_valid  (o_out.running_valid),
        .o_running_id     (o_out.running_id),
        .o_finished_valid (o_out.finished_valid),
        .o_finished_id    (o_out.finished_id),
        .o_finish_time    (o_out.finish_time),
        .o_all_done       (o_out.all_done),
        .o_time_now       (o_out.time_now)
    );

endmodule

/* rtl/cts_checker.sv */
// Port-level checks for the tick scheduler, bound to cpu_tick_scheduler_top.
// Depends only on the top level's ports.
module cts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_accepted,
    input logic       i_running_valid,
    input logic [7:0] i_running_id,
    input logic       i_finished_valid
);

    // one word in flight: never take input while a result waits
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid)) else $error("input taken while result pending");

    // a taken word blocks the input on the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready) else $error("input ready after accept");

    // a result word stays offered until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid) else $error("result dropped");

    // a load result carries no run or finish
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_accepted) |-> (!i_running_valid && !i_finished_valid))
        else $error("load result with tick fields");

    // idle tick reports id zero
    a_idle_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_running_valid) |-> (i_running_id == 8'd0))
        else $error("running id set while idle");

endmodule

bind cpu_tick_scheduler_top cts_checker u_cts_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_accepted       (o_out.accepted),
    .i_running_valid  (o_out.running_valid),
    .i_running_id     (o_out.running_id),
    .i_finished_valid (o_out.finished_valid)
);
